/* rtl/ultrasonic_echo_ranger_unit_assert.svh */
// Assertion macros for the echo ranger.
// UER_ASSERT_SAME: when ante holds, cons holds on the same edge.
// UER_ASSERT_NEXT: when ante holds, cons holds on the next edge.
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define UER_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UER_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/uer_pkg.sv */
`timescale 1ns / 1ps

package uer_pkg;

    typedef enum logic [1:0]
    {
        PH_IDLE = 2'd0,
        PH_PRE  = 2'd1,
        PH_HIGH = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE_US = 1'd1;

    localparam logic [15:0] ECHO_LIMIT_RST   = 16'd23330;
    localparam logic [9:0]  MIN_PULSE_US_RST = 10'd100;

    // trigger sequence lengths in ticks
    localparam logic [3:0] PRE_LOW_TICKS   = 4'd2;
    localparam logic [3:0] TRIG_HIGH_TICKS = 4'd10;

    // distance = duration * 0.017145, as (duration * 17978) >> 20
    localparam logic [14:0] DIST_MUL   = 15'd17978;
    localparam int unsigned DIST_SHIFT = 20;
    localparam int unsigned PROD_W     = 31;
    localparam logic [10:0] TIMEOUT_CM = 11'd400;

    typedef struct packed
    {
        logic        trig;
        logic        ready;
        logic        timed_out;
        logic [15:0] duration;
    } step_res_t;

endpackage

/* rtl/uer_req_if.sv */
`timescale 1ns / 1ps

interface uer_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic echo_level;

    modport source (output valid, output req_type, output echo_level, input ready);
    modport sink   (input valid, input req_type, input echo_level, output ready);
endinterface

/* rtl/uer_res_if.sv */
`timescale 1ns / 1ps

interface uer_res_if;
    logic        valid;
    logic        ready;
    logic        trig_out;
    logic        meas_done;
    logic        timed_out;
    logic [10:0] range_cm;

    modport source (output valid, output trig_out, output meas_done, output timed_out,
                    output range_cm, input ready);
    modport sink   (input valid, input trig_out, input meas_done, input timed_out,
                    input range_cm, output ready);
endinterface

/* rtl/uer_step.sv */
`timescale 1ns / 1ps

// Measurement state and its per-request update.
module uer_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                req_type,
    input  logic                echo_level,
    input  logic [15:0]         echo_limit,
    input  logic [9:0]          min_pulse_us,
    output uer_pkg::step_res_t  res
);

    uer_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  phase_ticks_reg, phase_ticks_next;
    logic [15:0] timeout_ticks_reg, timeout_ticks_next;
    logic [15:0] pulse_ticks_reg, pulse_ticks_next;
    logic [15:0] duration_reg, duration_next;
    logic        waiting_reg, waiting_next;
    logic        seen_reg, seen_next;
    logic        ready_reg, ready_next;
    logic        tmo_flag_reg, tmo_flag_next;
    logic        prev_echo_reg, prev_echo_next;
    logic        trig;
    logic [3:0]  pt_inc;

    assign pt_inc = phase_ticks_reg + 4'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        phase_ticks_next   = phase_ticks_reg;
        timeout_ticks_next = timeout_ticks_reg;
        pulse_ticks_next   = pulse_ticks_reg;
        duration_next      = duration_reg;
        waiting_next       = waiting_reg;
        seen_next          = seen_reg;
        ready_next         = ready_reg;
        tmo_flag_next      = tmo_flag_reg;
        prev_echo_next     = prev_echo_reg;
        trig               = 1'b0;

        if (req_type == uer_pkg::REQ_START)
        begin
            ready_next         = 1'b0;
            tmo_flag_next      = 1'b0;
            waiting_next       = 1'b1;
            seen_next          = 1'b0;
            pulse_ticks_next   = '0;
            timeout_ticks_next = '0;
            phase_next         = uer_pkg::PH_PRE;
            phase_ticks_next   = '0;
        end
        else
        begin
            case (phase_reg)
                uer_pkg::PH_PRE:
                begin
                    phase_ticks_next = pt_inc;
                    if (pt_inc >= uer_pkg::PRE_LOW_TICKS)
                    begin
                        phase_next       = uer_pkg::PH_HIGH;
                        phase_ticks_next = '0;
                    end
                end
                uer_pkg::PH_HIGH:
                begin
                    trig             = 1'b1;
                    phase_ticks_next = pt_inc;
                    if (pt_inc >= uer_pkg::TRIG_HIGH_TICKS)
                    begin
                        phase_next         = uer_pkg::PH_WAIT;
                        phase_ticks_next   = '0;
                        timeout_ticks_next = '0;
                    end
                end
                default: ;
            endcase

            // pulse counter runs from the first rising edge on
            if (seen_reg && pulse_ticks_reg != 16'hFFFF)
                pulse_ticks_next = pulse_ticks_reg + 16'd1;

            if (waiting_reg)
            begin
                if (echo_level && !prev_echo_reg)
                begin
                    if (!seen_reg)
                    begin
                        seen_next        = 1'b1;
                        pulse_ticks_next = '0;
                    end
                end
                else if (!echo_level && prev_echo_reg)
                begin
                    if (seen_reg && !ready_reg &&
                        pulse_ticks_next >= {6'd0, min_pulse_us} &&
                        pulse_ticks_next <= echo_limit)
                    begin
                        duration_next = pulse_ticks_next;
                        ready_next    = 1'b1;
                        tmo_flag_next = 1'b0;
                        waiting_next  = 1'b0;
                        phase_next    = uer_pkg::PH_IDLE;
                    end
                end
            end

            // timeout runs in the wait phase only; an echo result this tick wins
            if (phase_reg == uer_pkg::PH_WAIT && phase_next == uer_pkg::PH_WAIT)
            begin
                if (timeout_ticks_reg != 16'hFFFF)
                    timeout_ticks_next = timeout_ticks_reg + 16'd1;
                if (timeout_ticks_next >= echo_limit)
                begin
                    if (!ready_next)
                    begin
                        duration_next = echo_limit;
                        tmo_flag_next = 1'b1;
                        ready_next    = 1'b1;
                        waiting_next  = 1'b0;
                        seen_next     = 1'b0;
                    end
                    phase_next = uer_pkg::PH_IDLE;
                end
            end

            prev_echo_next = echo_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= uer_pkg::PH_IDLE;
            phase_ticks_reg   <= '0;
            timeout_ticks_reg <= '0;
            pulse_ticks_reg   <= '0;
            duration_reg      <= '0;
            waiting_reg       <= 1'b0;
            seen_reg          <= 1'b0;
            ready_reg         <= 1'b0;
            tmo_flag_reg      <= 1'b0;
            prev_echo_reg     <= 1'b0;
        end
        else if (en)
        begin
            phase_reg         <= phase_next;
            phase_ticks_reg   <= phase_ticks_next;
            timeout_ticks_reg <= timeout_ticks_next;
            pulse_ticks_reg   <= pulse_ticks_next;
            duration_reg      <= duration_next;
            waiting_reg       <= waiting_next;
            seen_reg          <= seen_next;
            ready_reg         <= ready_next;
            tmo_flag_reg      <= tmo_flag_next;
            prev_echo_reg     <= prev_echo_next;
        end
    end

    assign res.trig      = trig;
    assign res.ready     = ready_next;
    assign res.timed_out = tmo_flag_next;
    assign res.duration  = duration_next;

endmodule

/* rtl/ultrasonic_echo_ranger_unit.sv */
`timescale 1ns / 1ps

// Channel   Dir  Payload                                          Handshake
// req       in   req_type, echo_level                             valid/ready
// res       out  trig_out, meas_done, timed_out, range_cm         valid/ready
// cfg       in   cfg_idx (0 echo_limit, 1 min_pulse_us), cfg_data cfg_we
//
// One request is taken per cycle while req.ready is high; its result is registered
// in stage 1 (state update), then the distance multiply fills the output register.
// Throughput is set by the measurement state update.
// rst_n clears the measurement state and loads the register defaults.
// A stalled result port holds the output register; the middle stage still
// drains into a free output register, so req.ready drops only when both are full.

`include "ultrasonic_echo_ranger_unit_assert.svh"

module ultrasonic_echo_ranger_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    uer_req_if.sink                             req,
    uer_res_if.source                           res,
    input  logic                                cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // configuration registers
    logic [15:0] echo_limit_reg;
    logic [9:0]  min_pulse_us_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_limit_reg   <= uer_pkg::ECHO_LIMIT_RST;
            min_pulse_us_reg <= uer_pkg::MIN_PULSE_US_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                uer_pkg::REG_ECHO_LIMIT:   echo_limit_reg   <= cfg_data;
                uer_pkg::REG_MIN_PULSE_US: min_pulse_us_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // pipeline control: stage 1 holds the step result, stage 2 the output
    logic                s1_valid_reg;
    uer_pkg::step_res_t  s1_reg;
    logic                out_valid_reg;
    logic                out_en;
    logic                s1_move;
    logic                accept;
    uer_pkg::step_res_t  step_res;

    assign out_en    = !out_valid_reg || res.ready;
    assign s1_move   = s1_valid_reg && out_en;
    assign req.ready = !s1_valid_reg || out_en;
    assign accept    = req.valid && req.ready;

    uer_step u_step
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (accept),
        .req_type     (req.req_type),
        .echo_level   (req.echo_level),
        .echo_limit   (echo_limit_reg),
        .min_pulse_us (min_pulse_us_reg),
        .res          (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= step_res;
    end

    // distance: 16 x 15 multiply, keep bits above the fixed-point shift
    logic [uer_pkg::PROD_W-1:0] prod;
    logic [10:0]                range_val;

    assign prod = uer_pkg::PROD_W'(s1_reg.duration) * uer_pkg::PROD_W'(uer_pkg::DIST_MUL);

    always_comb
    begin
        if (!s1_reg.ready)
            range_val = '0;
        else if (s1_reg.timed_out)
            range_val = uer_pkg::TIMEOUT_CM;
        else
            range_val = prod[uer_pkg::DIST_SHIFT +: 11];
    end

    logic        trig_out_reg;
    logic        meas_done_reg;
    logic        timed_out_reg;
    logic [10:0] distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            trig_out_reg  <= s1_reg.trig;
            meas_done_reg <= s1_reg.ready;
            timed_out_reg <= s1_reg.timed_out;
            distance_reg  <= range_val;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.trig_out  = trig_out_reg;
    assign res.meas_done = meas_done_reg;
    assign res.timed_out = timed_out_reg;
    assign res.range_cm  = distance_reg;

    // checks
    `UER_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, accept, s1_valid_reg, "request lost")
    `UER_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !out_en, s1_valid_reg, "s1 dropped")
    `UER_ASSERT_SAME(a_tmo, clk, rst_n, s1_valid_reg && s1_reg.timed_out, s1_reg.ready, "no ready")
    `UER_ASSERT_SAME(a_rng0, clk, rst_n, res.valid && !res.meas_done, res.range_cm == '0, "range")

endmodule
